FILE: rtl/hnt_pkg.sv
package hnt_pkg;

   // default widths
   localparam int SAMPLE_BITS_DEF      = 16;
   localparam int VECTOR_FRAC_BITS_DEF = 14;

   // normalizer: the largest component is brought into [2^29, 2^30)
   localparam int NORM_W = 30;
   localparam int SQ_W   = 2 * NORM_W + 2;
   localparam int ROOT_W = SQ_W / 2;

   // register map
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_SCALE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SPACING = 1'b1;

   localparam logic [CSR_DATA_W-1:0] HEIGHT_SCALE_RST = 16'd25600;
   localparam logic [CSR_DATA_W-1:0] CELL_SPACING_RST = 16'd256;

   // tangent shorter than 0.001 falls back to the z axis
   localparam longint unsigned TINY_DIV = 64'd1000000;

   typedef struct packed {
      logic [15:0] height_left;
      logic [15:0] height_right;
      logic [15:0] height_down;
      logic [15:0] height_up;
   } hnt_req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic [14:0]        normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] tangent_x;
      logic signed [15:0] tangent_y;
      logic signed [15:0] tangent_z;
      logic               used_z_fallback;
   } hnt_rsp_type;

endpackage

FILE: rtl/hnt_unit.sv
module hnt_unit #(
   parameter int MAG_W  = 33,
   parameter int FRAC_W = 14,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [2:0][MAG_W-1:0]    in_mag,
   input  logic [2:0]               in_neg,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [2:0][FRAC_W+1:0]   out_comp,
   output logic                     out_zero,
   output logic [SIDE_W-1:0]        out_side
);
   import hnt_pkg::*;

   localparam int POS_W = (MAG_W > 1) ? $clog2(MAG_W) : 1;
   localparam int EXT_W = MAG_W + NORM_W;
   localparam int SH_W  = $clog2(EXT_W) + 1;
   localparam int TRY_W = SQ_W + 2;
   localparam int Q_W   = FRAC_W + 1;
   localparam int NUM_W = ROOT_W + FRAC_W + 1;
   localparam int C_W   = FRAC_W + 2;

   // stage 1: largest magnitude and its leading one
   logic [MAG_W-1:0] max_c;
   logic [POS_W-1:0] pos_c;

   always_comb begin
      max_c = in_mag[0];
      if (in_mag[1] > max_c) max_c = in_mag[1];
      if (in_mag[2] > max_c) max_c = in_mag[2];
      pos_c = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (max_c[i]) pos_c = POS_W'(i);
      end
   end

   logic                  s1_valid_ff;
   logic [2:0][MAG_W-1:0] s1_mag_ff;
   logic [2:0]            s1_neg_ff;
   logic                  s1_zero_ff;
   logic [POS_W-1:0]      s1_pos_ff;
   logic [SIDE_W-1:0]     s1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff  <= in_mag;
         s1_neg_ff  <= in_neg;
         s1_zero_ff <= (max_c == '0);
         s1_pos_ff  <= pos_c;
         s1_side_ff <= in_side;
      end
   end

   // stage 2: shift all lanes by the same amount
   logic [2:0][NORM_W-1:0] nrm_c;
   logic [EXT_W-1:0]       ext_c;
   logic [SH_W-1:0]        rsh_c;
   logic [SH_W-1:0]        lsh_c;

   always_comb begin
      rsh_c = SH_W'(s1_pos_ff) - SH_W'(NORM_W - 1);
      lsh_c = SH_W'(NORM_W - 1) - SH_W'(s1_pos_ff);
      ext_c = '0;
      for (int i = 0; i < 3; i++) begin
         ext_c = EXT_W'(s1_mag_ff[i]);
         if (SH_W'(s1_pos_ff) >= SH_W'(NORM_W - 1)) ext_c = ext_c >> rsh_c;
         else ext_c = ext_c << lsh_c;
         nrm_c[i] = ext_c[NORM_W-1:0];
      end
   end

   logic                   s2_valid_ff;
   logic [2:0][NORM_W-1:0] s2_nrm_ff;
   logic [2:0]             s2_neg_ff;
   logic                   s2_zero_ff;
   logic [SIDE_W-1:0]      s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_nrm_ff  <= nrm_c;
         s2_neg_ff  <= s1_neg_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // stage 3: squares
   logic                     s3_valid_ff;
   logic [2:0][2*NORM_W-1:0] s3_sq_ff;
   logic [2:0][NORM_W-1:0]   s3_nrm_ff;
   logic [2:0]               s3_neg_ff;
   logic                     s3_zero_ff;
   logic [SIDE_W-1:0]        s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) s3_sq_ff[i] <= s2_nrm_ff[i] * s2_nrm_ff[i];
         s3_nrm_ff  <= s2_nrm_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // stage 4: sum of squares enters the root pipeline
   logic                   rt_valid_ff [ROOT_W+1];
   logic [SQ_W-1:0]        rt_rem_ff   [ROOT_W+1];
   logic [ROOT_W-1:0]      rt_root_ff  [ROOT_W+1];
   logic [2:0][NORM_W-1:0] rt_nrm_ff   [ROOT_W+1];
   logic [2:0]             rt_neg_ff   [ROOT_W+1];
   logic                   rt_zero_ff  [ROOT_W+1];
   logic [SIDE_W-1:0]      rt_side_ff  [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) rt_valid_ff[0] <= 1'b0;
      else if (adv) rt_valid_ff[0] <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_rem_ff[0]  <= SQ_W'(s3_sq_ff[0]) + SQ_W'(s3_sq_ff[1]) + SQ_W'(s3_sq_ff[2]);
         rt_root_ff[0] <= '0;
         rt_nrm_ff[0]  <= s3_nrm_ff;
         rt_neg_ff[0]  <= s3_neg_ff;
         rt_zero_ff[0] <= s3_zero_ff;
         rt_side_ff[0] <= s3_side_ff;
      end
   end

   // floor square root, one result bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_root
      localparam int J = ROOT_W - 1 - k;
      logic [TRY_W-1:0] try_c;
      logic             take_c;

      assign try_c  = (TRY_W'(rt_root_ff[k]) << (J + 1)) + (TRY_W'(1) << (2 * J));
      assign take_c = TRY_W'(rt_rem_ff[k]) >= try_c;

      always_ff @(posedge clock) begin
         if (reset) rt_valid_ff[k+1] <= 1'b0;
         else if (adv) rt_valid_ff[k+1] <= rt_valid_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_rem_ff[k+1]  <= take_c ? SQ_W'(TRY_W'(rt_rem_ff[k]) - try_c) : rt_rem_ff[k];
            rt_root_ff[k+1] <= take_c ? (rt_root_ff[k] | (ROOT_W'(1) << J)) : rt_root_ff[k];
            rt_nrm_ff[k+1]  <= rt_nrm_ff[k];
            rt_neg_ff[k+1]  <= rt_neg_ff[k];
            rt_zero_ff[k+1] <= rt_zero_ff[k];
            rt_side_ff[k+1] <= rt_side_ff[k];
         end
      end
   end

   // rounded numerators, then restoring division
   logic                  dv_valid_ff [Q_W+1];
   logic [2:0][NUM_W-1:0] dv_rem_ff   [Q_W+1];
   logic [2:0][Q_W-1:0]   dv_q_ff     [Q_W+1];
   logic [ROOT_W-1:0]     dv_len_ff   [Q_W+1];
   logic [2:0]            dv_neg_ff   [Q_W+1];
   logic                  dv_zero_ff  [Q_W+1];
   logic [SIDE_W-1:0]     dv_side_ff  [Q_W+1];

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else if (adv) dv_valid_ff[0] <= rt_valid_ff[ROOT_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= (NUM_W'(rt_nrm_ff[ROOT_W][i]) << FRAC_W)
                             + NUM_W'(rt_root_ff[ROOT_W] >> 1);
         end
         dv_q_ff[0]    <= '0;
         dv_len_ff[0]  <= rt_root_ff[ROOT_W];
         dv_neg_ff[0]  <= rt_neg_ff[ROOT_W];
         dv_zero_ff[0] <= rt_zero_ff[ROOT_W];
         dv_side_ff[0] <= rt_side_ff[ROOT_W];
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int J = FRAC_W - k;
      logic [NUM_W-1:0] den_c;

      assign den_c = NUM_W'(dv_len_ff[k]) << J;

      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[k+1] <= 1'b0;
         else if (adv) dv_valid_ff[k+1] <= dv_valid_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               if (dv_rem_ff[k][i] >= den_c) begin
                  dv_rem_ff[k+1][i] <= dv_rem_ff[k][i] - den_c;
                  dv_q_ff[k+1][i]   <= dv_q_ff[k][i] | (Q_W'(1) << J);
               end else begin
                  dv_rem_ff[k+1][i] <= dv_rem_ff[k][i];
                  dv_q_ff[k+1][i]   <= dv_q_ff[k][i];
               end
            end
            dv_len_ff[k+1]  <= dv_len_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
            dv_side_ff[k+1] <= dv_side_ff[k];
         end
      end
   end

   // clamp to one and apply the sign
   logic [2:0][C_W-1:0] comp_c;
   logic [C_W-1:0]      mag_c;

   always_comb begin
      mag_c = '0;
      for (int i = 0; i < 3; i++) begin
         mag_c = C_W'(dv_q_ff[Q_W][i]);
         if (mag_c > (C_W'(1) << FRAC_W)) mag_c = C_W'(1) << FRAC_W;
         comp_c[i] = dv_neg_ff[Q_W][i] ? (~mag_c + C_W'(1)) : mag_c;
      end
   end

   logic                out_valid_ff;
   logic [2:0][C_W-1:0] out_comp_ff;
   logic                out_zero_ff;
   logic [SIDE_W-1:0]   out_side_ff;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= dv_valid_ff[Q_W];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_comp_ff <= comp_c;
         out_zero_ff <= dv_zero_ff[Q_W];
         out_side_ff <= dv_side_ff[Q_W];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_comp  = out_comp_ff;
   assign out_zero  = out_zero_ff;
   assign out_side  = out_side_ff;

endmodule

FILE: rtl/hnt_tangent.sv
module hnt_tangent #(
   parameter int FRAC_W = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [2:0][FRAC_W+1:0]      in_comp,
   input  logic                        in_zero,
   output logic                        out_valid,
   output logic [2:0][2*FRAC_W:0]      out_mag,
   output logic [2:0]                  out_neg,
   output logic [3*(FRAC_W+2):0]       out_side
);
   import hnt_pkg::*;

   localparam int C_W = FRAC_W + 2;
   localparam int P_W = 2 * C_W;
   localparam int M_W = 2 * FRAC_W + 1;
   localparam longint unsigned THR = ((64'd1 << (2 * FRAC_W)) - 64'd1) / TINY_DIV;

   // zero vector gives +y
   logic [C_W-1:0] nx_c, ny_c, nz_c;

   always_comb begin
      nx_c = in_zero ? '0 : in_comp[0];
      ny_c = in_zero ? (C_W'(1) << FRAC_W) : in_comp[1];
      nz_c = in_zero ? '0 : in_comp[2];
   end

   // stage 1: products of normal components
   logic                  t1_valid_ff;
   logic [C_W-1:0]        t1_nx_ff, t1_ny_ff, t1_nz_ff;
   logic signed [P_W-1:0] t1_pxx_ff, t1_pxy_ff, t1_pxz_ff, t1_pzy_ff, t1_pzz_ff;

   always_ff @(posedge clock) begin
      if (reset) t1_valid_ff <= 1'b0;
      else if (adv) t1_valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_nx_ff  <= nx_c;
         t1_ny_ff  <= ny_c;
         t1_nz_ff  <= nz_c;
         t1_pxx_ff <= $signed(nx_c) * $signed(nx_c);
         t1_pxy_ff <= $signed(nx_c) * $signed(ny_c);
         t1_pxz_ff <= $signed(nx_c) * $signed(nz_c);
         t1_pzy_ff <= $signed(nz_c) * $signed(ny_c);
         t1_pzz_ff <= $signed(nz_c) * $signed(nz_c);
      end
   end

   // stage 2: gram-schmidt from +x, or from +z when too short
   logic signed [P_W-1:0] one2_c, tx_c;
   logic signed [P_W-1:0] v_c [3];
   logic [P_W-1:0]        abs_c;
   logic                  fb_c;
   logic [2:0][M_W-1:0]   mag_c;
   logic [2:0]            neg_c;

   always_comb begin
      one2_c = P_W'(1) << (2 * FRAC_W);
      tx_c   = one2_c - t1_pxx_ff;
      fb_c   = $unsigned(tx_c) <= P_W'(THR);
      if (!fb_c) begin
         v_c[0] = tx_c;
         v_c[1] = -t1_pxy_ff;
         v_c[2] = -t1_pxz_ff;
      end else begin
         v_c[0] = -t1_pxz_ff;
         v_c[1] = -t1_pzy_ff;
         v_c[2] = one2_c - t1_pzz_ff;
      end
      abs_c = '0;
      for (int i = 0; i < 3; i++) begin
         neg_c[i] = v_c[i] < 0;
         abs_c    = neg_c[i] ? $unsigned(-v_c[i]) : $unsigned(v_c[i]);
         mag_c[i] = abs_c[M_W-1:0];
      end
   end

   logic                  t2_valid_ff;
   logic [2:0][M_W-1:0]   t2_mag_ff;
   logic [2:0]            t2_neg_ff;
   logic [3*C_W:0]        t2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) t2_valid_ff <= 1'b0;
      else if (adv) t2_valid_ff <= t1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_mag_ff  <= mag_c;
         t2_neg_ff  <= neg_c;
         t2_side_ff <= {fb_c, t1_nx_ff, t1_ny_ff, t1_nz_ff};
      end
   end

   assign out_valid = t2_valid_ff;
   assign out_mag   = t2_mag_ff;
   assign out_neg   = t2_neg_ff;
   assign out_side  = t2_side_ff;

endmodule

FILE: rtl/heightmap_normal_tangent.sv
// channel  ports                           moves
// req      req_valid/req_ready/req_data    four neighbour heights, one vertex a beat
// rsp      rsp_valid/rsp_ready/rsp_data    unit normal, unit tangent, fallback flag
// csr      csr_we/csr_index/csr_wdata      height_scale, cell_spacing writes
//
// one beat in and one beat out per cycle when unstalled. the two
// normalizers each hold a 31-stage square root and a quotient divider
// of VECTOR_FRAC_BITS+1 stages.
// reset is synchronous: valid bits clear, registers return to defaults.
// the whole pipeline holds while a result beat waits on rsp_ready.
module heightmap_normal_tangent #(
   parameter int SAMPLE_BITS      = hnt_pkg::SAMPLE_BITS_DEF,
   parameter int VECTOR_FRAC_BITS = hnt_pkg::VECTOR_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  hnt_pkg::hnt_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output hnt_pkg::hnt_rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [hnt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hnt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hnt_pkg::*;

   localparam int S     = SAMPLE_BITS;
   localparam int F     = VECTOR_FRAC_BITS;
   localparam int N_W   = S + CSR_DATA_W + 1;
   localparam int C_W   = F + 2;
   localparam int T_W   = 2 * F + 1;
   localparam int SD_W  = 3 * C_W + 1;

   logic adv;

   // configuration registers
   logic [CSR_DATA_W-1:0] height_scale_ff;
   logic [CSR_DATA_W-1:0] cell_spacing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_scale_ff <= HEIGHT_SCALE_RST;
         cell_spacing_ff <= CELL_SPACING_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HEIGHT_SCALE: height_scale_ff <= csr_wdata;
            CSR_CELL_SPACING: cell_spacing_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // the pipeline moves unless a result beat is stuck
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage a: height differences
   logic [S-1:0] hl_c, hr_c, hd_c, hu_c;
   logic         a_valid_ff;
   logic [S-1:0] a_dx_ff, a_dz_ff;
   logic         a_nx_ff, a_nz_ff;

   assign hl_c = req_data.height_left[S-1:0];
   assign hr_c = req_data.height_right[S-1:0];
   assign hd_c = req_data.height_down[S-1:0];
   assign hu_c = req_data.height_up[S-1:0];

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (adv) a_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dx_ff <= (hl_c >= hr_c) ? hl_c - hr_c : hr_c - hl_c;
         a_nx_ff <= hl_c < hr_c;
         a_dz_ff <= (hd_c >= hu_c) ? hd_c - hu_c : hu_c - hd_c;
         a_nz_ff <= hd_c < hu_c;
      end
   end

   // stage b: scale to world units
   logic                b_valid_ff;
   logic [2:0][N_W-1:0] b_mag_ff;
   logic [2:0]          b_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (adv) b_valid_ff <= a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_mag_ff[0] <= N_W'(a_dx_ff * height_scale_ff);
         b_mag_ff[1] <= N_W'(cell_spacing_ff) << (S + 1);
         b_mag_ff[2] <= N_W'(a_dz_ff * height_scale_ff);
         b_neg_ff    <= {a_nz_ff, 1'b0, a_nx_ff};
      end
   end

   // normal
   logic                n_valid;
   logic [2:0][C_W-1:0] n_comp;
   logic                n_zero;

   hnt_unit #(
      .MAG_W  (N_W),
      .FRAC_W (F),
      .SIDE_W (1)
   ) u_norm_n (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (b_valid_ff),
      .in_mag    (b_mag_ff),
      .in_neg    (b_neg_ff),
      .in_side   (1'b0),
      .out_valid (n_valid),
      .out_comp  (n_comp),
      .out_zero  (n_zero),
      .out_side  ()
   );

   // tangent vector
   logic                tv_valid;
   logic [2:0][T_W-1:0] tv_mag;
   logic [2:0]          tv_neg;
   logic [SD_W-1:0]     tv_side;

   hnt_tangent #(
      .FRAC_W (F)
   ) u_tangent (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n_valid),
      .in_comp   (n_comp),
      .in_zero   (n_zero),
      .out_valid (tv_valid),
      .out_mag   (tv_mag),
      .out_neg   (tv_neg),
      .out_side  (tv_side)
   );

   // tangent normalize, normal rides along
   logic                t_valid;
   logic [2:0][C_W-1:0] t_comp;
   logic                t_zero;
   logic [SD_W-1:0]     t_side;

   hnt_unit #(
      .MAG_W  (T_W),
      .FRAC_W (F),
      .SIDE_W (SD_W)
   ) u_norm_t (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (tv_valid),
      .in_mag    (tv_mag),
      .in_neg    (tv_neg),
      .in_side   (tv_side),
      .out_valid (t_valid),
      .out_comp  (t_comp),
      .out_zero  (t_zero),
      .out_side  (t_side)
   );

   // result register
   hnt_rsp_type    rsp_data_in;
   hnt_rsp_type    rsp_data_ff;
   logic [C_W-1:0] tx_c;

   always_comb begin
      tx_c = t_zero ? (C_W'(1) << F) : t_comp[0];
      rsp_data_in.normal_x        = 16'($signed(t_side[3*C_W-1:2*C_W]));
      rsp_data_in.normal_y        = 15'($signed(t_side[2*C_W-1:C_W]));
      rsp_data_in.normal_z        = 16'($signed(t_side[C_W-1:0]));
      rsp_data_in.tangent_x       = 16'($signed(tx_c));
      rsp_data_in.tangent_y       = t_zero ? '0 : 16'($signed(t_comp[1]));
      rsp_data_in.tangent_z       = t_zero ? '0 : 16'($signed(t_comp[2]));
      rsp_data_in.used_z_fallback = t_side[3*C_W];
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= t_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/hnt_checker.sv
module hnt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input hnt_pkg::hnt_rsp_type rsp_data
);
   import hnt_pkg::*;

   // a waiting result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stuck result stops the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stuck");

   // input stays open while nothing waits
   a_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind heightmap_normal_tangent hnt_checker u_hnt_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import hnt_pkg::*;

   localparam int FRAC      = VECTOR_FRAC_BITS_DEF;
   localparam longint ONE_F = longint'(1) << FRAC;
   localparam longint ONE_2F = longint'(1) << (2 * FRAC);
   localparam int SETTLE    = 2 * FRAC + 81 + 20;
   localparam int LIMIT     = 600000;

   localparam hnt_rsp_type FLAT_RSP = '{normal_x: 16'sd0, normal_y: 15'd16384,
      normal_z: 16'sd0, tangent_x: 16'sd16384, tangent_y: 16'sd0, tangent_z: 16'sd0,
      used_z_fallback: 1'b0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hnt_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hnt_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_HEIGHT_SCALE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   heightmap_normal_tangent dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow of the block's registers
   longint unsigned scale_q = 64'd25600;
   longint unsigned cell_q  = 64'd256;

   hnt_rsp_type vertex_q[$];
   int mismatches = 0;
   int cycles = 0;
   bit gaps_on = 1'b1;

   // expectation override for directed rows with a typed result
   bit beat_typed = 1'b0;
   hnt_rsp_type beat_typed_rsp = '0;

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale to [2^29, 2^30), then divide each magnitude by the length
   function automatic bit unit_vec(input longint unsigned a0, a1, a2,
                                   input bit s0, s1, s2,
                                   output longint o0, o1, o2);
      longint unsigned m, len, q0, q1, q2;
      m = a0;
      if (a1 > m) m = a1;
      if (a2 > m) m = a2;
      if (m == 0) return 1'b0;
      while (m >= (64'd1 << 30)) begin
         m = m >> 1; a0 = a0 >> 1; a1 = a1 >> 1; a2 = a2 >> 1;
      end
      while (m < (64'd1 << 29)) begin
         m = m << 1; a0 = a0 << 1; a1 = a1 << 1; a2 = a2 << 1;
      end
      len = root64(a0 * a0 + a1 * a1 + a2 * a2);
      if (len == 0) len = 1;
      q0 = ((a0 << FRAC) + (len >> 1)) / len;
      q1 = ((a1 << FRAC) + (len >> 1)) / len;
      q2 = ((a2 << FRAC) + (len >> 1)) / len;
      if (q0 > ONE_F) q0 = ONE_F;
      if (q1 > ONE_F) q1 = ONE_F;
      if (q2 > ONE_F) q2 = ONE_F;
      o0 = s0 ? -longint'(q0) : longint'(q0);
      o1 = s1 ? -longint'(q1) : longint'(q1);
      o2 = s2 ? -longint'(q2) : longint'(q2);
      return 1'b1;
   endfunction

   function automatic longint unsigned absl(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic hnt_rsp_type vertex_frame(hnt_req_type d);
      longint unsigned hl, hr, hd, hu, mx, mz;
      longint nx, ny, nz, t0, t1, t2, ux, uy, uz;
      bit fb;
      hnt_rsp_type r;
      hl = d.height_left; hr = d.height_right;
      hd = d.height_down; hu = d.height_up;
      mx = (hl >= hr ? hl - hr : hr - hl) * scale_q;
      mz = (hd >= hu ? hd - hu : hu - hd) * scale_q;
      if (!unit_vec(mx, cell_q << 17, mz, hl < hr, 1'b0, hd < hu, nx, ny, nz)) begin
         nx = 0; ny = ONE_F; nz = 0;
      end
      // gram-schmidt from +x, +z when the x tangent is too short
      t0 = ONE_2F - nx * nx;
      fb = (longint'(t0) * 1000000) < ONE_2F;
      if (!fb) begin
         t1 = -(nx * ny);
         t2 = -(nx * nz);
      end else begin
         t0 = -(nz * nx);
         t1 = -(nz * ny);
         t2 = ONE_2F - nz * nz;
      end
      if (!unit_vec(absl(t0), absl(t1), absl(t2), t0 < 0, t1 < 0, t2 < 0, ux, uy, uz)) begin
         ux = ONE_F; uy = 0; uz = 0;
      end
      r.normal_x = nx[15:0];
      r.normal_y = ny[14:0];
      r.normal_z = nz[15:0];
      r.tangent_x = ux[15:0];
      r.tangent_y = uy[15:0];
      r.tangent_z = uz[15:0];
      r.used_z_fallback = fb;
      return r;
   endfunction

   // input and result monitors, scoreboard, timeout
   always @(posedge clock) begin
      hnt_rsp_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: errors");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready)
            vertex_q.insert(vertex_q.size(),
                            beat_typed ? beat_typed_rsp : vertex_frame(req_data));
         if (rsp_valid && rsp_ready) begin
            if (vertex_q.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected result beat %p", rsp_data);
            end else begin
               e = vertex_q.pop_front();
               if (rsp_data !== e) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("mismatch exp %p got %p", e, rsp_data);
               end
            end
         end
      end
   end

   // result side stalls
   initial begin
      @(negedge reset);
      forever begin
         if (gaps_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   task automatic send_vertex(hnt_req_type d, bit typed, hnt_rsp_type te);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      beat_typed <= typed;
      beat_typed_rsp <= te;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (vertex_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(longint unsigned sc, longint unsigned ce);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_HEIGHT_SCALE;
      csr_wdata <= sc[15:0];
      @(posedge clock);
      csr_index <= CSR_CELL_SPACING;
      csr_wdata <= ce[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      scale_q = sc;
      cell_q = ce;
      @(posedge clock);
   endtask

   function automatic hnt_req_type rand_vertex();
      hnt_req_type d;
      int k;
      d = {$urandom, $urandom};
      k = $urandom_range(0, 5);
      // gentle slopes, flat and edge samples, and fully random ones
      if (k < 2) begin
         d.height_right = d.height_left + 16'($urandom_range(0, 64)) - 16'd32;
         d.height_up = d.height_down + 16'($urandom_range(0, 64)) - 16'd32;
      end else if (k == 2) begin
         d.height_right = d.height_left;
         if ($urandom_range(0, 1)) d.height_up = d.height_down;
      end else if (k == 3) begin
         d.height_left = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         d.height_right = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      return d;
   endfunction

   typedef struct {
      int unsigned sc;
      int unsigned ce;
      hnt_req_type d;
      bit typed;
      hnt_rsp_type e;
   } vertex_row_type;

   vertex_row_type rows[$];

   function automatic vertex_row_type row(int unsigned sc, int unsigned ce,
                                          logic [15:0] l, r, dn, u, bit typed);
      vertex_row_type v;
      v.sc = sc; v.ce = ce;
      v.d = '{height_left: l, height_right: r, height_down: dn, height_up: u};
      v.typed = typed;
      v.e = FLAT_RSP;
      return v;
   endfunction

   task automatic add_row(vertex_row_type v);
      rows.insert(rows.size(), v);
   endtask

   initial begin
      int unsigned set_sc[9] = '{25600, 0, 65535, 65535, 1, 0, 0, 0, 0};
      int unsigned set_ce[9] = '{256, 1, 1, 65535, 65535, 0, 0, 0, 0};
      int per_set;
      hnt_req_type d;

      // directed rows: flat maps, extremes, degenerate tangent, zero vector
      add_row(row(25600, 256, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1));
      add_row(row(25600, 256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
      add_row(row(25600, 256, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 0));
      add_row(row(25600, 256, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0));
      add_row(row(25600, 256, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 0));
      add_row(row(25600, 256, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 0));
      add_row(row(25600, 256, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 0));
      add_row(row(0, 1, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1));
      add_row(row(65535, 1, 16'hFFFF, 16'h0000, 16'h1234, 16'h1234, 0));
      add_row(row(65535, 1, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0));
      add_row(row(65535, 1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 0));
      add_row(row(65535, 1, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 0));
      add_row(row(65535, 0, 16'h8000, 16'h8000, 16'h0001, 16'h0001, 1));
      add_row(row(65535, 0, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 0));
      add_row(row(65535, 0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 0));
      add_row(row(65535, 65535, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 0));
      add_row(row(1, 65535, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 0));
      add_row(row(1, 1, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, registers rewritten only when a row needs new ones
      foreach (rows[i]) begin
         if (rows[i].sc != scale_q || rows[i].ce != cell_q)
            write_regs(rows[i].sc, rows[i].ce);
         send_vertex(rows[i].d, rows[i].typed, rows[i].e);
      end

      // random part over several register settings
      for (int s = 5; s < 9; s++) begin
         set_sc[s] = $urandom_range(0, 65535);
         set_ce[s] = $urandom_range(1, 65535);
      end
      per_set = 88;
      for (int s = 0; s < 9; s++) begin
         write_regs(set_sc[s], set_ce[s]);
         if (s == 8) gaps_on = 1'b0;
         for (int n = 0; n < per_set; n++) begin
            d = rand_vertex();
            if (s == 2 && n == 40) begin
               // hold off until every pending vertex is out
               req_valid <= 1'b0;
               do @(posedge clock); while (vertex_q.size() != 0);
            end
            send_vertex(d, 1'b0, FLAT_RSP);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
